@@ rtl/core/union_find_token_pair_cost_defines.svh @@
// Assertion macros shared by the checker.
`ifndef UNION_FIND_TOKEN_PAIR_COST_DEFINES_SVH
`define UNION_FIND_TOKEN_PAIR_COST_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define UF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uf check failed");

// Next-cycle implication checked outside reset.
`define UF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uf check failed");

`endif

@@ rtl/core/uftpc_pkg.sv @@
`timescale 1ns / 1ps
package uftpc_pkg;

  localparam int NumVertices = 1024;
  localparam int VtxW = $clog2(NumVertices);
  localparam int CntW = 11;
  localparam int SizeW = VtxW + 1;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    REQ_TOKEN_A = 2'd0,
    REQ_TOKEN_B = 2'd1,
    REQ_EDGE    = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  vertex_u;
    logic [9:0]  vertex_v;
    logic [31:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic        joined;
    logic [10:0] pairs_matched;
    logic [63:0] total_cost;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_TOK_A = 2'd1,
    CMD_TOK_B = 2'd2,
    CMD_EDGE  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [VtxW-1:0] vu;
    logic [VtxW-1:0] vv;
    logic [31:0]     weight;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } q_ctl_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_TOK_RD, S_TOK_WR,
    S_FIND_RD, S_FIND_CHK, S_COMP_RD, S_COMP_WR,
    S_RD_SZ, S_RD_SZ2, S_RD_CNT, S_RD_CNT2, S_SUM, S_MUL, S_MUL2, S_WB, S_DONE
  } bk_state_t;

endpackage

@@ rtl/core/union_find_token_pair_cost.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                  | Handshake
// request  | start, busy, request   | taken when start && !busy
// result   | done, result           | one-cycle strobe, cannot stall
// A token request passes the idle, read, write and done states of the back end.
// An edge walks each root path, root included, reading and checking each vertex,
// then compresses it, reading and writing each vertex, as the parent memory has
// one read and one write port. A join ends in the done state; the done strobe
// follows. After reset a clearing pass sets the memories; requests queue in the
// 2-entry queue meanwhile. busy rises when that queue is full.
module union_find_token_pair_cost (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  uftpc_pkg::in_item_t  request,
  output logic                 busy,
  output logic                 done,
  output uftpc_pkg::out_item_t result
);
  import uftpc_pkg::*;

  cmd_t   f_cmd;
  cmd_t   q_cmd;
  logic   push;
  logic   pop;
  q_ctl_t ctl;

  uftpc_front u_front (
    .start, .request, .q_full(ctl.full), .busy, .push, .cmd(f_cmd));

  uftpc_queue u_queue (
    .clk, .rst, .push, .wdata(f_cmd), .pop, .rdata(q_cmd), .ctl);

  uftpc_back u_back (
    .clk, .rst, .cmd(q_cmd), .q_empty(ctl.empty), .pop, .done, .result);

endmodule

@@ rtl/core/uftpc_ram.sv @@
`timescale 1ns / 1ps
module uftpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/uftpc_front.sv @@
`timescale 1ns / 1ps
module uftpc_front (
  input  logic                 start,
  input  uftpc_pkg::in_item_t  request,
  input  logic                 q_full,
  output logic                 busy,
  output logic                 push,
  output uftpc_pkg::cmd_t      cmd
);
  import uftpc_pkg::*;

  logic u_ok;
  logic v_ok;

  // The front stalls only while the queue is full.
  assign busy = q_full;
  assign push = start && !q_full;

  // Range checks and classification of the request.
  always_comb begin
    u_ok = ({1'b0, request.vertex_u} < (VtxW + 1)'(NumVertices));
    v_ok = ({1'b0, request.vertex_v} < (VtxW + 1)'(NumVertices));
    cmd.vu = request.vertex_u[VtxW-1:0];
    cmd.vv = request.vertex_v[VtxW-1:0];
    cmd.weight = request.edge_weight;
    cmd.kind = CMD_NOP;
    case (req_type_t'(request.req_type))
      REQ_TOKEN_A: if (u_ok) cmd.kind = CMD_TOK_A;
      REQ_TOKEN_B: if (u_ok) cmd.kind = CMD_TOK_B;
      REQ_EDGE:    if (u_ok && v_ok) cmd.kind = CMD_EDGE;
      default:     cmd.kind = CMD_NOP;
    endcase
  end

endmodule

@@ rtl/core/uftpc_queue.sv @@
`timescale 1ns / 1ps
module uftpc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  uftpc_pkg::cmd_t   wdata,
  input  logic              pop,
  output uftpc_pkg::cmd_t   rdata,
  output uftpc_pkg::q_ctl_t ctl
);
  import uftpc_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t            slots [QueueDepth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [PtrW:0]   fill;

  assign rdata = slots[rptr];
  assign ctl.full = (fill == (PtrW + 1)'(QueueDepth));
  assign ctl.empty = (fill == '0);
  assign ctl.push = push;
  assign ctl.pop = pop;

  // Small circular buffer of classified requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

@@ rtl/core/uftpc_back.sv @@
`timescale 1ns / 1ps
module uftpc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  uftpc_pkg::cmd_t      cmd,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 done,
  output uftpc_pkg::out_item_t result
);
  import uftpc_pkg::*;

  bk_state_t state;
  bk_state_t state_next;

  // Memory ports.
  logic              p_we;
  logic [VtxW-1:0]   p_waddr, p_raddr, p_wdata, p_rdata;
  logic              s_we;
  logic [VtxW-1:0]   s_waddr, s_raddr;
  logic [SizeW-1:0]  s_wdata, s_rdata;
  logic              a_we;
  logic [VtxW-1:0]   a_waddr, a_raddr;
  logic [CntW-1:0]   a_wdata, a_rdata;
  logic              b_we;
  logic [VtxW-1:0]   b_waddr, b_raddr;
  logic [CntW-1:0]   b_wdata, b_rdata;

  // Working registers.
  cmd_t            cur;
  logic [VtxW-1:0] clr;
  logic            side;
  logic [VtxW-1:0] walk;
  logic [VtxW-1:0] root_v;
  logic [VtxW-1:0] root_u;
  logic [SizeW-1:0] size_v;
  logic [SizeW-1:0] size_u;
  logic [CntW-1:0]  av, bv, sa, sb, matched;
  logic [CntW:0]    sum_a, sum_b;
  logic [42:0]      prod;
  logic [63:0]      running_total;
  logic [VtxW-1:0]  keep, gone;

  uftpc_ram #(.Width(VtxW), .Depth(NumVertices)) u_parent (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata));
  uftpc_ram #(.Width(SizeW), .Depth(NumVertices)) u_size (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));
  uftpc_ram #(.Width(CntW), .Depth(NumVertices)) u_cnt_a (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata));
  uftpc_ram #(.Width(CntW), .Depth(NumVertices)) u_cnt_b (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));

  assign keep = (size_v > size_u) ? root_v : root_u;
  assign gone = (size_v > size_u) ? root_u : root_v;
  assign sum_a = {1'b0, av} + {1'b0, a_rdata};
  assign sum_b = {1'b0, bv} + {1'b0, b_rdata};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (clr == VtxW'(NumVertices - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (!q_empty) begin
          case (cmd.kind)
            CMD_TOK_A, CMD_TOK_B: state_next = S_TOK_RD;
            CMD_EDGE:             state_next = S_FIND_RD;
            default:              state_next = S_DONE;
          endcase
        end
      end
      S_TOK_RD:   state_next = S_TOK_WR;
      S_TOK_WR:   state_next = S_DONE;
      S_FIND_RD:  state_next = S_FIND_CHK;
      S_FIND_CHK: state_next = (p_rdata == walk) ? S_COMP_RD : S_FIND_RD;
      S_COMP_RD:  state_next = S_COMP_WR;
      S_COMP_WR: begin
        if (walk == (side ? root_u : root_v) || p_rdata == walk) begin
          state_next = side ? ((root_u == root_v) ? S_DONE : S_RD_SZ) : S_FIND_RD;
        end else begin
          state_next = S_COMP_RD;
        end
      end
      S_RD_SZ:   state_next = S_RD_SZ2;
      S_RD_SZ2:  state_next = S_RD_CNT;
      S_RD_CNT:  state_next = S_RD_CNT2;
      S_RD_CNT2: state_next = S_SUM;
      S_SUM:     state_next = S_MUL;
      S_MUL:     state_next = S_MUL2;
      S_MUL2:    state_next = S_WB;
      S_WB:      state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory addresses and write enables by state.
  always_comb begin
    p_we = 1'b0;
    p_waddr = walk;
    p_wdata = side ? root_u : root_v;
    p_raddr = walk;
    s_we = 1'b0;
    s_waddr = keep;
    s_wdata = size_v + size_u;
    s_raddr = root_v;
    a_we = 1'b0;
    a_waddr = cur.vu;
    a_wdata = (a_rdata == CntMax) ? a_rdata : a_rdata + 1'b1;
    a_raddr = cur.vu;
    b_we = 1'b0;
    b_waddr = cur.vu;
    b_wdata = (b_rdata == CntMax) ? b_rdata : b_rdata + 1'b1;
    b_raddr = cur.vu;
    pop = (state == S_IDLE) && !q_empty;
    case (state)
      S_CLEAR: begin
        p_we = 1'b1; s_we = 1'b1; a_we = 1'b1; b_we = 1'b1;
        p_waddr = clr; p_wdata = clr;
        s_waddr = clr; s_wdata = SizeW'(1);
        a_waddr = clr; a_wdata = '0;
        b_waddr = clr; b_wdata = '0;
      end
      S_TOK_WR: begin
        a_we = (cur.kind == CMD_TOK_A);
        b_we = (cur.kind == CMD_TOK_B);
      end
      S_COMP_WR: begin
        p_we = 1'b1;
      end
      S_RD_SZ:  s_raddr = root_u;
      // The counts of both roots are summed, so read them by root rather
      // than by keep and gone, which wait on the second size.
      S_RD_SZ2: begin
        a_raddr = root_v;
        b_raddr = root_v;
      end
      S_RD_CNT: begin
        a_raddr = root_u;
        b_raddr = root_u;
      end
      S_WB: begin
        s_we = 1'b1;
        p_we = 1'b1; p_waddr = gone; p_wdata = keep;
        a_we = 1'b1; a_waddr = keep; a_wdata = sa - matched;
        b_we = 1'b1; b_waddr = keep; b_wdata = sb - matched;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      running_total <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      case (state)
        S_CLEAR: clr <= clr + 1'b1;
        S_IDLE: begin
          cur <= cmd;
          side <= 1'b0;
          walk <= cmd.vv;
          result.joined <= 1'b0;
          result.pairs_matched <= '0;
        end
        S_FIND_CHK: begin
          if (p_rdata == walk) begin
            if (side) root_u <= walk; else root_v <= walk;
            walk <= side ? cur.vu : cur.vv;
          end else begin
            walk <= p_rdata;
          end
        end
        S_COMP_WR: begin
          if (walk == (side ? root_u : root_v) || p_rdata == walk) begin
            side <= 1'b1;
            walk <= cur.vu;
          end else begin
            walk <= p_rdata;
          end
        end
        S_RD_SZ:  size_v <= s_rdata;
        S_RD_SZ2: size_u <= s_rdata;
        S_RD_CNT: begin
          av <= a_rdata;
          bv <= b_rdata;
        end
        S_RD_CNT2: begin
          sa <= sum_a[CntW] ? CntMax : sum_a[CntW-1:0];
          sb <= sum_b[CntW] ? CntMax : sum_b[CntW-1:0];
        end
        S_SUM: matched <= (sa < sb) ? sa : sb;
        S_MUL: prod <= 43'(matched) * 43'(cur.weight);
        S_MUL2: begin
          running_total <= running_total + 64'(prod);
          result.joined <= 1'b1;
          result.pairs_matched <= matched;
        end
        S_DONE: begin
          done <= 1'b1;
          result.total_cost <= running_total;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/uftpc_checker.sv @@
`timescale 1ns / 1ps
`include "union_find_token_pair_cost_defines.svh"
module uftpc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 busy,
  input logic                 done,
  input uftpc_pkg::out_item_t result
);
  import uftpc_pkg::*;

  `UF_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `UF_ASSERT_IMP(a_nojoin_zero, clk, rst, done && !result.joined, result.pairs_matched == '0)
  `UF_ASSERT_IMP(a_result_known, clk, rst, done, !$isunknown(result))
  `UF_ASSERT_IMP(a_match_bound, clk, rst, done, result.pairs_matched <= 11'd2047)
  `UF_ASSERT_IMP(a_busy_known, clk, rst, 1'b1, !$isunknown({busy, done}))

endmodule

bind union_find_token_pair_cost uftpc_checker u_checker (
  .clk, .rst, .busy, .done, .result);
